// File: hw/rtl/edit_distance_engine_defines.svh
// Assertion helpers for the edit distance engine.
// Both expect clk and rst_n in the scope where they are used.
`ifndef EDIT_DISTANCE_ENGINE_DEFINES_SVH
`define EDIT_DISTANCE_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define EDE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define EDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ede_pkg.sv
package ede_pkg;

    localparam int SYM_W  = 8;
    localparam int COST_W = 11;
    localparam int OP_W   = 2;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    localparam int MAX_REF_LEN_DEF   = 64;
    localparam int MAX_QUERY_LEN_DEF = 1024;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_QUERY  = 2'd1,
        OP_FINISH = 2'd2
    } ede_op_t;

    // Data handed from one cell to the next as the wavefront moves right.
    typedef struct packed {
        logic              vld;
        logic [SYM_W-1:0]  sym;
        logic [COST_W-1:0] cost;   // new cost of this column for the current query
        logic [COST_W-1:0] diag;   // cost of this column for the previous query
    } ede_link_t;

    function automatic logic [COST_W-1:0] sat_inc(input logic [COST_W-1:0] v);
        return (v == COST_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [COST_W-1:0] min2(input logic [COST_W-1:0] a,
                                               input logic [COST_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

// File: hw/rtl/ede_if.sv
interface ede_req_if;
    logic                        valid;
    logic                        ready;
    logic [ede_pkg::OP_W-1:0]    opcode;
    logic [ede_pkg::SYM_W-1:0]   symbol;

    modport source (output valid, output opcode, output symbol, input ready);
    modport sink   (input valid, input opcode, input symbol, output ready);
endinterface

interface ede_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ede_pkg::COST_W-1:0]  distance;
    logic                        overflow;

    modport source (output valid, output distance, output overflow, input ready);
    modport sink   (input valid, input distance, input overflow, output ready);
endinterface

// File: hw/rtl/ede_cell.sv
module ede_cell #(
    parameter int IDX = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       load,
    input  logic [ede_pkg::SYM_W-1:0]  load_sym,
    input  ede_pkg::ede_link_t         prev,
    output ede_pkg::ede_link_t         next
);

    localparam logic [ede_pkg::COST_W-1:0] COST_RST = ede_pkg::COST_W'(IDX);

    logic [ede_pkg::SYM_W-1:0]  ref_reg;
    logic                       active_reg, active_next;
    logic [ede_pkg::COST_W-1:0] cost_reg, cost_next;
    logic                       vld_reg, vld_next;
    logic [ede_pkg::SYM_W-1:0]  sym_reg;
    logic [ede_pkg::COST_W-1:0] diag_reg;

    logic [ede_pkg::COST_W-1:0] up_inc;
    logic [ede_pkg::COST_W-1:0] left_inc;
    logic [ede_pkg::COST_W-1:0] sub_cost;
    logic [ede_pkg::COST_W-1:0] best;

    always_comb
    begin
        up_inc   = ede_pkg::sat_inc(cost_reg);
        left_inc = ede_pkg::sat_inc(prev.cost);
        sub_cost = (ref_reg != prev.sym) ? ede_pkg::sat_inc(prev.diag) : prev.diag;
        best     = ede_pkg::min2(ede_pkg::min2(up_inc, left_inc), sub_cost);

        active_next = active_reg;
        cost_next   = cost_reg;
        vld_next    = 1'b0;
        if (clear)
        begin
            active_next = 1'b0;
            cost_next   = COST_RST;
        end
        else
        begin
            if (load)
            begin
                active_next = 1'b1;
            end
            if (prev.vld)
            begin
                vld_next = 1'b1;
                // columns past the reference carry the last real column along
                cost_next = active_reg ? best : prev.cost;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cost_reg   <= COST_RST;
            vld_reg    <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            cost_reg   <= cost_next;
            vld_reg    <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ref_reg <= load_sym;
        end
        if (prev.vld)
        begin
            sym_reg  <= prev.sym;
            diag_reg <= cost_reg;
        end
    end

    assign next.vld  = vld_reg;
    assign next.sym  = sym_reg;
    assign next.cost = cost_reg;
    assign next.diag = diag_reg;

endmodule

// File: hw/rtl/edit_distance_engine.sv
// Channel | Dir | Payload           | Request moves
// req     | in  | opcode, symbol    | load, query symbol or finish
// rsp     | out | distance, overflow| one result per finish
//
// Load and query requests are taken one per cycle, back to back.
// A query enters the cell chain through the column-0 register and moves
// through the MAX_REF_LEN cells in turn; finish stalls until that wavefront
// has left the chain and the result register is free, so it is taken only
// once the drain count has run out, later while a result waits.
// Reset leaves every cell at its starting cost with no clearing pass;
// finish clears the block at the end of the cycle in which it is taken.
`include "edit_distance_engine_defines.svh"

module edit_distance_engine #(
    parameter int MAX_REF_LEN   = ede_pkg::MAX_REF_LEN_DEF,
    parameter int MAX_QUERY_LEN = ede_pkg::MAX_QUERY_LEN_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ede_req_if.sink      req,
    ede_rsp_if.source    rsp
);

    localparam int LEN_W  = $clog2(MAX_REF_LEN + 1);
    localparam int QCNT_W = $clog2(MAX_QUERY_LEN + 1);

    logic [LEN_W-1:0]  len_reg, len_next;
    logic [QCNT_W-1:0] qcnt_reg, qcnt_next;
    logic              ovf_reg, ovf_next;
    logic [LEN_W-1:0]  drain_reg, drain_next;

    logic                       c0_vld_reg, c0_vld_next;
    logic [ede_pkg::SYM_W-1:0]  c0_sym_reg;
    logic [ede_pkg::COST_W-1:0] c0_cost_reg, c0_cost_next;
    logic [ede_pkg::COST_W-1:0] c0_diag_reg;

    logic                       rsp_vld_reg, rsp_vld_next;
    logic [ede_pkg::COST_W-1:0] dist_reg;
    logic                       rsp_ovf_reg;

    logic              req_fire;
    logic              is_load, is_query, is_finish;
    logic              load_go, query_go, finish_go;
    logic              slot_free;
    logic [QCNT_W-1:0] qcnt_inc;
    logic [ede_pkg::COST_W-1:0] dist_next;

    ede_pkg::ede_link_t link [0:MAX_REF_LEN];

    always_comb
    begin
        is_load   = 1'b0;
        is_query  = 1'b0;
        is_finish = 1'b0;
        case (req.opcode)
            ede_pkg::OP_LOAD:   is_load   = 1'b1;
            ede_pkg::OP_QUERY:  is_query  = 1'b1;
            ede_pkg::OP_FINISH: is_finish = 1'b1;
            default:            ;
        endcase
    end

    assign slot_free = !rsp_vld_reg || rsp.ready;
    assign req.ready = !is_finish || ((drain_reg == '0) && slot_free);
    assign req_fire  = req.valid && req.ready;

    assign load_go   = req_fire && is_load && (qcnt_reg == '0)
                       && (len_reg != LEN_W'(MAX_REF_LEN));
    assign query_go  = req_fire && is_query && (qcnt_reg != QCNT_W'(MAX_QUERY_LEN));
    assign finish_go = req_fire && is_finish;
    assign qcnt_inc  = qcnt_reg + 1'b1;

    assign dist_next = (qcnt_reg == '0) ? ede_pkg::COST_W'(len_reg)
                                        : link[MAX_REF_LEN].cost;

    always_comb
    begin
        len_next     = len_reg;
        qcnt_next    = qcnt_reg;
        ovf_next     = ovf_reg;
        drain_next   = (drain_reg != '0) ? drain_reg - 1'b1 : drain_reg;
        c0_vld_next  = 1'b0;
        c0_cost_next = c0_cost_reg;
        rsp_vld_next = rsp_vld_reg && !rsp.ready;

        if (finish_go)
        begin
            len_next     = '0;
            qcnt_next    = '0;
            ovf_next     = 1'b0;
            c0_cost_next = '0;
            rsp_vld_next = 1'b1;
        end
        else if (load_go)
        begin
            len_next = len_reg + 1'b1;
        end
        else if (query_go)
        begin
            qcnt_next    = qcnt_inc;
            drain_next   = LEN_W'(MAX_REF_LEN);
            c0_vld_next  = 1'b1;
            c0_cost_next = (32'(qcnt_inc) >= 32'(ede_pkg::COST_MAX))
                           ? ede_pkg::COST_MAX : ede_pkg::COST_W'(qcnt_inc);
        end
        else if (req_fire && (is_load || is_query) && !load_go)
        begin
            // drop: reference full or query too long (load after query is silent)
            if (is_query || (qcnt_reg == '0))
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            qcnt_reg    <= '0;
            ovf_reg     <= 1'b0;
            drain_reg   <= '0;
            c0_vld_reg  <= 1'b0;
            c0_cost_reg <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            len_reg     <= len_next;
            qcnt_reg    <= qcnt_next;
            ovf_reg     <= ovf_next;
            drain_reg   <= drain_next;
            c0_vld_reg  <= c0_vld_next;
            c0_cost_reg <= c0_cost_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            c0_sym_reg  <= req.symbol;
            c0_diag_reg <= c0_cost_reg;
        end
        if (finish_go)
        begin
            dist_reg    <= dist_next;
            rsp_ovf_reg <= ovf_reg;
        end
    end

    assign link[0].vld  = c0_vld_reg;
    assign link[0].sym  = c0_sym_reg;
    assign link[0].cost = c0_cost_reg;
    assign link[0].diag = c0_diag_reg;

    for (genvar k = 1; k <= MAX_REF_LEN; k++)
    begin : g_cell
        ede_cell #(
            .IDX (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (finish_go),
            .load     (load_go && (len_reg == LEN_W'(k - 1))),
            .load_sym (req.symbol),
            .prev     (link[k - 1]),
            .next     (link[k])
        );
    end

    assign rsp.valid    = rsp_vld_reg;
    assign rsp.distance = dist_reg;
    assign rsp.overflow = rsp_ovf_reg;

    `EDE_ASSERT_NOW(a_finish_drained, finish_go, drain_reg == '0,
                    "finish taken with wavefront in flight")
    `EDE_ASSERT_NEXT(a_finish_clears, finish_go,
                     rsp_vld_reg && len_reg == '0 && qcnt_reg == '0,
                     "finish did not post result and clear")
    `EDE_ASSERT_NEXT(a_query_enters, query_go,
                     link[0].vld && drain_reg == LEN_W'(MAX_REF_LEN),
                     "query did not enter chain")
    `EDE_ASSERT_NOW(a_len_bound, 1'b1, len_reg <= LEN_W'(MAX_REF_LEN),
                    "reference length past limit")

endmodule
